// ----- hw/rtl/fct_pkg.sv -----
// fct_pkg: shared types and constants of the frustum cull test
// plane layout, primitive codes, reset planes and pipeline advance struct
// no dependencies
`default_nettype none

package fct_pkg;

  localparam int NUM_PLANES      = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int NORM_W          = 16;
  localparam int OFS_W           = 16;
  localparam int FRAC_SHIFT      = 14;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int CMD_W           = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_POINT  = 2'd0,
    CMD_SPHERE = 2'd1,
    CMD_BOX    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // packed high to low: nx, ny, nz (Q1.14), d (Q8.8)
  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic signed [OFS_W-1:0]  d;
  } plane_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_adv_t;

  localparam logic [NUM_PLANES-1:0][CFG_DATA_W-1:0] PLANE_RST = {
    64'h0000_0000_C000_0100,
    64'h0000_0000_4000_0100,
    64'h0000_C000_0000_0100,
    64'h0000_4000_0000_0100,
    64'hC000_0000_0000_0100,
    64'h4000_0000_0000_0100
  };

endpackage

`default_nettype wire

// ----- hw/rtl/fct_cfg.sv -----
// fct_cfg: register file of the six frustum planes
// depends on fct_pkg
`default_nettype none

module fct_cfg
  import fct_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output plane_t [NUM_PLANES-1:0]    planes_o
);

  logic [NUM_PLANES-1:0][CFG_DATA_W-1:0] plane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= PLANE_RST;
    end else if (cfg_valid_i) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        if (cfg_index_i == CFG_IDX_W'(k)) begin
          plane_q[k] <= cfg_data_i;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PLANES; k++) begin
      planes_o[k] = plane_t'(plane_q[k]);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fct_pipe_ctrl.sv -----
// fct_pipe_ctrl: valid bits and stage advance of the three-stage pipeline
// depends on fct_pkg
`default_nettype none

module fct_pipe_ctrl
  import fct_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic out_stall_i,
  output pipe_adv_t adv_o,
  output logic      in_stall_o,
  output logic      out_valid_o
);

  logic v1_q, v2_q, v3_q;

  always_comb begin
    adv_o.s3 = !v3_q || !out_stall_i;
    adv_o.s2 = !v2_q || adv_o.s3;
    adv_o.s1 = !v1_q || adv_o.s2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv_o.s1) v1_q <= in_valid_i;
      if (adv_o.s2) v2_q <= v1_q;
      if (adv_o.s3) v3_q <= v2_q;
    end
  end

  assign in_stall_o  = !adv_o.s1;
  assign out_valid_o = v3_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fct_plane_eval.sv -----
// fct_plane_eval: signed distance of the chosen vertex to one plane
// stage 1 vertex select and products, stage 2 sum with scaled offset; depends on fct_pkg
`default_nettype none

module fct_plane_eval
  import fct_pkg::*;
#(
  parameter int CoordW = COORD_WIDTH_DEF,
  parameter int SumW   = ((CoordW > OFS_W) ? CoordW : OFS_W) + 19
) (
  input  wire logic                           clk_i,
  input  wire pipe_adv_t                      adv_i,
  input  wire plane_t                         plane_i,
  input  wire logic                           is_box_i,
  input  wire logic [2:0][CoordW-1:0]         lo_i,
  input  wire logic [2:0][CoordW-1:0]         hi_i,
  output logic signed [SumW-1:0]              dist_o
);

  localparam int ProdW = NORM_W + CoordW;

  logic signed [NORM_W-1:0] nrm [3];
  logic [CoordW-1:0]        pick [3];
  logic signed [ProdW-1:0]  n_ext [3];
  logic signed [ProdW-1:0]  p_ext [3];
  logic signed [ProdW-1:0]  prod_d [3];
  logic signed [ProdW-1:0]  prod_q [3];
  logic signed [SumW-1:0]   dist_d;
  logic signed [SumW-1:0]   dist_q;
  logic signed [OFS_W-1:0]  ofs_q;

  assign nrm[0] = plane_i.nx;
  assign nrm[1] = plane_i.ny;
  assign nrm[2] = plane_i.nz;

  // positive vertex of a box: max corner where the normal component is not negative; other primitives use lo
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pick[a]   = (is_box_i && !nrm[a][NORM_W-1]) ? hi_i[a] : lo_i[a];
      n_ext[a]  = ProdW'(nrm[a]);
      p_ext[a]  = ProdW'($signed(pick[a]));
      prod_d[a] = n_ext[a] * p_ext[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      prod_q <= prod_d;
      ofs_q  <= plane_i.d;
    end
  end

  always_comb begin
    dist_d = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2])
           + (SumW'(ofs_q) <<< FRAC_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

// ----- hw/rtl/frustum_cull_test.sv -----
// frustum_cull_test: six-plane culling test of a point, sphere or box
// depends on fct_pkg, fct_cfg, fct_pipe_ctrl, fct_plane_eval
//
//   channel | handshake                | payload
//   in      | in_valid_i / in_stall_o  | cmd_i, lo_*_i, hi_*_i, radius_i
//   out     | out_valid_o / out_stall_i| inside_res_o
//   cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one item per cycle while no output stall holds the pipeline; each stage registers its result
// stage 1 vertex select and products, stage 2 plane sums, stage 3 compare
// an output stall holds each full stage with no empty stage after it; other stages still move and fill
// reset clears the valid bits and loads the default unit-cube planes
`default_nettype none

module frustum_cull_test
  import fct_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [CMD_W-1:0]        cmd_i,
  input  wire logic [COORD_WIDTH-1:0]  lo_x_i,
  input  wire logic [COORD_WIDTH-1:0]  lo_y_i,
  input  wire logic [COORD_WIDTH-1:0]  lo_z_i,
  input  wire logic [COORD_WIDTH-1:0]  hi_x_i,
  input  wire logic [COORD_WIDTH-1:0]  hi_y_i,
  input  wire logic [COORD_WIDTH-1:0]  hi_z_i,
  input  wire logic [COORD_WIDTH-1:0]  radius_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         inside_res_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int SumW = ((COORD_WIDTH > OFS_W) ? COORD_WIDTH : OFS_W) + 19;

  plane_t [NUM_PLANES-1:0]        planes;
  pipe_adv_t                      adv;
  cmd_e                           cmd;
  logic [2:0][COORD_WIDTH-1:0]    lo;
  logic [2:0][COORD_WIDTH-1:0]    hi;
  logic signed [SumW-1:0]         plane_dist [NUM_PLANES];
  logic signed [SumW-1:0]         margin [NUM_PLANES];
  logic [NUM_PLANES-1:0]          pass;
  logic [COORD_WIDTH-1:0]         rad1_d, rad1_q, rad2_q;
  logic                           live1_d, live1_q, live2_q;
  logic                           inside_d, inside_q;

  assign cfg_ready_o = 1'b1;

  fct_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .planes_o    (planes)
  );

  fct_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .adv_o       (adv),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  assign cmd   = cmd_e'(cmd_i);
  assign lo[0] = lo_x_i;
  assign lo[1] = lo_y_i;
  assign lo[2] = lo_z_i;
  assign hi[0] = hi_x_i;
  assign hi[1] = hi_y_i;
  assign hi[2] = hi_z_i;

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_plane
    fct_plane_eval #(
      .CoordW (COORD_WIDTH),
      .SumW   (SumW)
    ) u_eval (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .plane_i  (planes[k]),
      .is_box_i (cmd == CMD_BOX),
      .lo_i     (lo),
      .hi_i     (hi),
      .dist_o   (plane_dist[k])
    );
  end

  // radius only counts for a sphere; unused command never passes
  always_comb begin
    rad1_d  = (cmd == CMD_SPHERE) ? radius_i : '0;
    live1_d = (cmd != CMD_NONE);
  end

  always_ff @(posedge clk_i) begin
    if (adv.s1) begin
      rad1_q  <= rad1_d;
      live1_q <= live1_d;
    end
    if (adv.s2) begin
      rad2_q  <= rad1_q;
      live2_q <= live1_q;
    end
  end

  // distance >= -radius, i.e. distance + radius is not negative
  always_comb begin
    for (int k = 0; k < NUM_PLANES; k++) begin
      margin[k] = plane_dist[k] + $signed(SumW'({rad2_q, {FRAC_SHIFT{1'b0}}}));
      pass[k]   = !margin[k][SumW-1];
    end
    inside_d = live2_q && (&pass);
  end

  always_ff @(posedge clk_i) begin
    if (adv.s3) begin
      inside_q <= inside_d;
    end
  end

  assign inside_res_o = inside_q;

endmodule

`default_nettype wire

// ----- verif/frustum_cull_test_tb.sv -----
// frustum_cull_test_tb: self-checking bench for the six-plane frustum cull test
// directed table at reset planes, then random primitives under several plane sets
// depends on fct_pkg and frustum_cull_test
`timescale 1ns / 1ps

module frustum_cull_test_tb;
  import fct_pkg::*;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int USE_MODEL   = -1;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDX_SPAN    = 1 << CFG_IDX_W;

  localparam logic [CFG_DATA_W-1:0] RESET_PLANES [NUM_PLANES] = '{
    64'h4000_0000_0000_0100, 64'hC000_0000_0000_0100,
    64'h0000_4000_0000_0100, 64'h0000_C000_0000_0100,
    64'h0000_0000_4000_0100, 64'h0000_0000_C000_0100
  };

  typedef struct packed {
    cmd_e            cmd;
    logic [CW-1:0]   lx, ly, lz;
    logic [CW-1:0]   hx, hy, hz;
    logic [CW-1:0]   rad;
  } prim_t;

  typedef struct {
    cmd_e            cmd;
    logic [CW-1:0]   lx, ly, lz, hx, hy, hz, rad;
    int              want;
  } row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      cmd_i       = '0;
  logic [CW-1:0]         lo_x_i      = '0;
  logic [CW-1:0]         lo_y_i      = '0;
  logic [CW-1:0]         lo_z_i      = '0;
  logic [CW-1:0]         hi_x_i      = '0;
  logic [CW-1:0]         hi_y_i      = '0;
  logic [CW-1:0]         hi_z_i      = '0;
  logic [CW-1:0]         radius_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  inside_res_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  plane_t planes [NUM_PLANES];
  bit     expected_inside [$];
  bit     want_inside;
  int     mismatches  = 0;
  int     cycle_count = 0;
  int     stall_mode  = 0;
  int     stall_left  = 0;
  int     stall_ctr   = 0;
  int     burst_left  = 1;

  row_t dir_rows [22] = '{
    '{CMD_POINT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1},
    '{CMD_POINT,  16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1},
    '{CMD_POINT,  16'hFF00, 16'hFF00, 16'hFF00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1},
    '{CMD_POINT,  16'h0101, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0},
    '{CMD_POINT,  16'h0000, 16'hFEFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0},
    '{CMD_POINT,  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0},
    '{CMD_POINT,  16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 0},
    '{CMD_SPHERE, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0200, 1},
    '{CMD_SPHERE, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h01FF, 0},
    '{CMD_SPHERE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1},
    '{CMD_SPHERE, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1},
    '{CMD_SPHERE, 16'h0000, 16'h0000, 16'hFC00, 16'h0000, 16'h0000, 16'h0000, 16'h0300, 1},
    '{CMD_SPHERE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1},
    '{CMD_BOX,    16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1},
    '{CMD_BOX,    16'h0200, 16'h0000, 16'h0000, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 0},
    '{CMD_BOX,    16'h0100, 16'h0100, 16'h0100, 16'h0500, 16'h0500, 16'h0500, 16'h0000, 1},
    '{CMD_BOX,    16'h0200, 16'h0000, 16'h0000, 16'hFE00, 16'h0000, 16'h0000, 16'h0000, 0},
    '{CMD_BOX,    16'h0080, 16'h0080, 16'h0080, 16'hFF80, 16'hFF80, 16'hFF80, 16'h0000, 1},
    '{CMD_NONE,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0},
    '{CMD_NONE,   16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 0},
    '{CMD_BOX,    16'h0123, 16'hFE45, 16'h0067, 16'h0A00, 16'hFF00, 16'h0010, 16'h0000,
      USE_MODEL},
    '{CMD_SPHERE, 16'h0250, 16'h0180, 16'hFE80, 16'h0000, 16'h0000, 16'h0000, 16'h0120,
      USE_MODEL}
  };

  frustum_cull_test dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .lo_x_i      (lo_x_i),
    .lo_y_i      (lo_y_i),
    .lo_z_i      (lo_z_i),
    .hi_x_i      (hi_x_i),
    .hi_y_i      (hi_y_i),
    .hi_z_i      (hi_z_i),
    .radius_i    (radius_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .inside_res_o(inside_res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit inside_frustum(prim_t p);
    logic signed [CW-1:0]     lo [3];
    logic signed [CW-1:0]     hi [3];
    logic signed [NORM_W-1:0] n [3];
    logic signed [CW-1:0]     c;
    longint                   pdist;
    longint                   limit;
    bit                       ok;
    if (p.cmd == CMD_NONE) return 1'b0;
    lo = '{p.lx, p.ly, p.lz};
    hi = '{p.hx, p.hy, p.hz};
    limit = 0;
    if (p.cmd == CMD_SPHERE) limit = -(longint'(p.rad) << FRAC_SHIFT);
    ok = 1'b1;
    for (int i = 0; i < NUM_PLANES; i++) begin
      n = '{planes[i].nx, planes[i].ny, planes[i].nz};
      pdist = longint'($signed(planes[i].d)) << FRAC_SHIFT;
      for (int a = 0; a < 3; a++) begin
        c = lo[a];
        if (p.cmd == CMD_BOX && n[a] >= 0) c = hi[a];
        pdist += longint'(n[a]) * longint'(c);
      end
      if (pdist < limit) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [CW-1:0] rand_coord(bit wide);
    int t;
    if (wide) return CW'($urandom);
    t = $urandom_range(0, 16'h1000);
    t -= 16'h0800;
    return CW'(t);
  endfunction

  function automatic prim_t random_prim();
    prim_t p;
    int    sel;
    bit    wide;
    sel  = $urandom_range(0, 9);
    wide = ($urandom_range(0, 3) == 0);
    p.cmd = sel < 3 ? CMD_POINT : sel < 6 ? CMD_SPHERE : sel < 9 ? CMD_BOX : CMD_NONE;
    p.lx = rand_coord(wide);
    p.ly = rand_coord(wide);
    p.lz = rand_coord(wide);
    if ($urandom_range(0, 4) == 0) begin
      p.hx = CW'($urandom);
      p.hy = CW'($urandom);
      p.hz = CW'($urandom);
    end else begin
      p.hx = p.lx + CW'($urandom_range(0, 16'h0600));
      p.hy = p.ly + CW'($urandom_range(0, 16'h0600));
      p.hz = p.lz + CW'($urandom_range(0, 16'h0600));
    end
    p.rad = ($urandom_range(0, 7) == 0) ? CW'($urandom) : CW'($urandom_range(0, 16'h0400));
    return p;
  endfunction

  // one face of a slightly tilted random box around the origin
  function automatic logic [CFG_DATA_W-1:0] cube_plane(int idx);
    logic signed [NORM_W-1:0] comp [3];
    logic [NORM_W-1:0]        mag;
    int                       tilt;
    plane_t                   pl;
    for (int a = 0; a < 3; a++) begin
      tilt = $urandom_range(0, 16'h0800);
      tilt -= 16'h0400;
      comp[a] = ($urandom_range(0, 1) == 0) ? '0 : NORM_W'(tilt);
    end
    mag = ($urandom_range(0, 1) == 0) ? 16'h4000 : NORM_W'($urandom_range(16'h0800, 16'h7FFF));
    comp[idx / 2] = (idx % 2) ? -mag : mag;
    pl.nx = comp[0];
    pl.ny = comp[1];
    pl.nz = comp[2];
    pl.d  = OFS_W'($urandom_range(0, 16'h0600));
    return pl;
  endfunction

  task automatic send_prim(prim_t p, bit want);
    in_valid_i <= 1'b1;
    cmd_i      <= p.cmd;
    lo_x_i     <= p.lx;
    lo_y_i     <= p.ly;
    lo_z_i     <= p.lz;
    hi_x_i     <= p.hx;
    hi_y_i     <= p.hy;
    hi_z_i     <= p.hz;
    radius_i   <= p.rad;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_inside.push_back(want);
  endtask

  task automatic send_random(int count);
    prim_t p;
    int    gap;
    for (int k = 0; k < count; k++) begin
      p = random_prim();
      send_prim(p, inside_frustum(p));
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  task automatic wait_results();
    while (expected_inside.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_plane(int idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_IDX_W'(idx);
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx < NUM_PLANES) planes[idx] = val;
  endtask

  task automatic load_planes(int ph);
    logic [CFG_DATA_W-1:0] v;
    for (int i = 0; i < NUM_PLANES; i++) begin
      case (ph)
        0:       v = '0;
        1:       v = '1;
        2:       v = (i % 2) ? 64'h8000_8000_8000_8000 : 64'h7FFF_7FFF_7FFF_7FFF;
        5:       v = {$urandom, $urandom};
        default: v = cube_plane(i);
      endcase
      write_plane(i, v);
    end
    // writes past the last plane must leave the planes alone
    if (ph == 3 || ph == 6) begin
      for (int i = NUM_PLANES; i < IDX_SPAN; i++) write_plane(i, {$urandom, $urandom});
    end
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_ctr <= stall_ctr + 1;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= (stall_ctr % 5) < 2;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_inside.size() == 0) begin
        if (mismatches < 10) $display("unexpected item: inside_res %0b", inside_res_o);
        mismatches++;
      end else begin
        want_inside = expected_inside.pop_front();
        if (inside_res_o !== want_inside) begin
          if (mismatches < 10) begin
            $display("inside_res mismatch: expected %0b, got %0b", want_inside, inside_res_o);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("frustum_cull_test_tb NOT OK");
      $finish;
    end
  end

  initial begin
    prim_t p;
    for (int i = 0; i < NUM_PLANES; i++) planes[i] = RESET_PLANES[i];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < $size(dir_rows); r++) begin
      p = '{dir_rows[r].cmd, dir_rows[r].lx, dir_rows[r].ly, dir_rows[r].lz,
            dir_rows[r].hx, dir_rows[r].hy, dir_rows[r].hz, dir_rows[r].rad};
      send_prim(p, dir_rows[r].want == USE_MODEL ? inside_frustum(p) : dir_rows[r].want[0]);
    end
    in_valid_i <= 1'b0;
    wait_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_planes(ph);
      send_random(PHASE_ITEMS);
      in_valid_i <= 1'b0;
      wait_results();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("frustum_cull_test_tb OK");
    end else begin
      $display("frustum_cull_test_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/fct_pkg.sv
hw/rtl/fct_cfg.sv
hw/rtl/fct_pipe_ctrl.sv
hw/rtl/fct_plane_eval.sv
hw/rtl/frustum_cull_test.sv
verif/frustum_cull_test_tb.sv
